@@ hdl/psp_pkg.sv @@
package psp_pkg;

	// register indexes on the configuration port
	localparam logic CFG_PACK_MODE   = 1'b0;
	localparam logic CFG_ALPHA_VALUE = 1'b1;

	// packing mode codes
	localparam logic [2:0] MODE_DENSE  = 3'd0;
	localparam logic [2:0] MODE_ALPHA  = 3'd1;
	localparam logic [2:0] MODE_BYTE   = 3'd2;
	localparam logic [2:0] MODE_HALF   = 3'd3;
	localparam logic [2:0] MODE_CHROMA = 3'd4;

	// output word queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one output beat
	typedef struct packed {
		logic [31:0] data;
		logic        user;
		logic        last;
	} word_t;

	// words produced by one input beat
	typedef struct packed {
		logic [1:0]      cnt;
		word_t [2:0]     words;
	} pack_res_t;

endpackage

@@ hdl/psp_pack.sv @@
module psp_pack
	import psp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_accept,
	input  logic [23:0] pix,
	input  logic        pix_user,
	input  logic        pix_last,
	output logic [1:0]  need,
	output pack_res_t   res
);

	logic [2:0]        mode_q;
	logic [7:0]        alpha_q;
	logic [2:0][23:0]  buf_q;
	logic [1:0]        fill_q;
	logic [2:0]        marks_q;

	logic              pair_grp;
	logic              mode_ok;
	logic [1:0]        n;
	logic              flush;
	logic [3:0][23:0]  p;
	logic [3:0]        u;
	logic              anyu;
	logic [8:0]        sum_c1;
	logic [8:0]        sum_c2;
	logic [31:0]       w0;
	logic [31:0]       w1;
	logic [31:0]       w2;

	// group slot selection and word assembly
	always_comb begin
		mode_ok  = (mode_q == MODE_DENSE) || (mode_q == MODE_ALPHA) || (mode_q == MODE_BYTE)
			|| (mode_q == MODE_HALF) || (mode_q == MODE_CHROMA);
		pair_grp = (mode_q == MODE_HALF) || (mode_q == MODE_CHROMA);
		n        = (pair_grp && fill_q != 2'd0) ? 2'd1 : fill_q;
		flush    = pix_last || (pair_grp ? (n == 2'd1) : (n == 2'd3));

		for (int i = 0; i < 3; i++) begin
			if (2'(i) < n) begin
				p[i] = buf_q[i];
				u[i] = marks_q[i];
			end else if (2'(i) == n) begin
				p[i] = pix;
				u[i] = pix_user;
			end else begin
				p[i] = '0;
				u[i] = 1'b0;
			end
		end
		p[3] = (n == 2'd3) ? pix : '0;
		u[3] = (n == 2'd3) ? pix_user : 1'b0;
		anyu = |u;

		sum_c1 = {1'b0, p[0][15:8]} + {1'b0, p[1][15:8]};
		sum_c2 = {1'b0, p[0][23:16]} + {1'b0, p[1][23:16]};

		w0 = '0;
		w1 = '0;
		w2 = '0;
		res = '0;
		need = 2'd0;
		case (mode_q)
			MODE_DENSE: begin
				w0 = {p[1][7:0], p[0]};
				w1 = {p[2][15:0], p[1][23:8]};
				w2 = {p[3], p[2][23:16]};
				case (n)
					2'd0:    need = 2'd1;
					2'd1:    need = 2'd2;
					default: need = 2'd3;
				endcase
				if (flush) begin
					res.cnt = need;
					res.words[0] = '{data: w0, user: u[0], last: pix_last && need == 2'd1};
					res.words[1] = '{data: w1, user: u[1], last: pix_last && need == 2'd2};
					res.words[2] = '{data: w2, user: u[2], last: pix_last && need == 2'd3};
				end
			end
			MODE_ALPHA: begin
				need = 2'd1;
				res.cnt = 2'd1;
				res.words[0] = '{data: {alpha_q, pix}, user: pix_user, last: pix_last};
			end
			MODE_BYTE: begin
				need = 2'd1;
				w0 = {p[3][7:0], p[2][7:0], p[1][7:0], p[0][7:0]};
				res.cnt = flush ? 2'd1 : 2'd0;
				res.words[0] = '{data: w0, user: anyu, last: pix_last};
			end
			MODE_HALF: begin
				need = 2'd1;
				w0 = {p[1][15:0], p[0][15:0]};
				res.cnt = flush ? 2'd1 : 2'd0;
				res.words[0] = '{data: w0, user: anyu, last: pix_last};
			end
			MODE_CHROMA: begin
				need = 2'd1;
				w0 = {sum_c2[8:1], p[1][7:0], sum_c1[8:1], p[0][7:0]};
				res.cnt = flush ? 2'd1 : 2'd0;
				res.words[0] = '{data: w0, user: anyu, last: pix_last};
			end
			default: begin
				need = 2'd0;
			end
		endcase
	end

	// configuration and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ALPHA;
			alpha_q <= '0;
			buf_q   <= '0;
			fill_q  <= '0;
			marks_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_PACK_MODE) begin
				mode_q  <= cfg_data[2:0];
				buf_q   <= '0;
				fill_q  <= '0;
				marks_q <= '0;
			end else begin
				alpha_q <= cfg_data;
			end
		end else if (in_accept && mode_ok && mode_q != MODE_ALPHA) begin
			if (flush) begin
				buf_q   <= '0;
				fill_q  <= '0;
				marks_q <= '0;
			end else begin
				buf_q[n]   <= pix;
				marks_q[n] <= pix_user;
				fill_q     <= n + 2'd1;
			end
		end
	end

endmodule

@@ hdl/psp_word_queue.sv @@
module psp_word_queue
	import psp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  word_t [2:0]       push_words,
	output logic [QCNT_W-1:0] count,
	output word_t             head,
	output logic              head_valid,
	input  logic              head_ready
);

	word_t [QUEUE_DEPTH-1:0] q_q;
	logic [QCNT_W-1:0]       cnt_q;
	logic                    pop;
	logic [QCNT_W-1:0]       base;
	logic [QCNT_W-1:0]       rel;
	word_t [QUEUE_DEPTH-1:0] shifted;
	word_t [QUEUE_DEPTH-1:0] q_next;

	assign pop        = (cnt_q != '0) && head_ready;
	assign count      = cnt_q;
	assign head       = q_q[0];
	assign head_valid = cnt_q != '0;

	// shift out the popped beat and append new beats behind the survivors
	always_comb begin
		base = cnt_q - QCNT_W'(pop);
		rel  = '0;
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			if (pop && j < QUEUE_DEPTH - 1) begin
				shifted[j] = q_q[j + 1];
			end else begin
				shifted[j] = q_q[j];
			end
		end
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			rel = QCNT_W'(j) - base;
			if (QCNT_W'(j) < base) begin
				q_next[j] = shifted[j];
			end else if (rel < QCNT_W'(push_cnt)) begin
				q_next[j] = push_words[rel[1:0]];
			end else begin
				q_next[j] = shifted[j];
			end
		end
	end

	// beat storage holds no reset
	always_ff @(posedge clk) begin
		q_q <= q_next;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + QCNT_W'(push_cnt);
		end
	end

endmodule

@@ hdl/pixel_stream_packer.sv @@
// pixel packer: 24-bit pixels in, 32-bit words out, one pixel accepted per cycle
// a completing beat's word is queued and shown in the cycle after if the queue was empty
// throughput: one pixel per cycle in every mode while the output takes a word per cycle;
// no mode makes more than one word per pixel, so input stalls come only from output stalls
// reset: mode 1 (alpha), alpha byte 0, no pixels gathered, word queue empty
module pixel_stream_packer
	import psp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_data[23:0]
	input  logic        s_axis_tuser,   // pixel_user
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // word_data[31:0]
	output logic        m_axis_tuser,   // word_user
	output logic        m_axis_tlast
);

	logic              in_accept;
	logic [1:0]        need;
	pack_res_t         res;
	logic [QCNT_W-1:0] qcount;
	word_t             head;

	// accept only when the queue can hold the most words this beat may produce
	assign s_axis_tready = (QCNT_W'(qcount) + QCNT_W'(need)) <= QCNT_W'(QUEUE_DEPTH);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	psp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.pix       (s_axis_tdata),
		.pix_user  (s_axis_tuser),
		.pix_last  (s_axis_tlast),
		.need      (need),
		.res       (res)
	);

	psp_word_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (in_accept ? res.cnt : 2'd0),
		.push_words (res.words),
		.count      (qcount),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready)
	);

	assign m_axis_tdata = head.data;
	assign m_axis_tuser = head.user;
	assign m_axis_tlast = head.last;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import psp_pkg::*;

	// pack_mode code with no packing defined, pixels are swallowed
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int RANDOM_PIXELS = 100;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_MAX    = 10;

	// reference packer plus the queue of words it still owes
	class pack_scoreboard;
		logic [2:0]  mode;
		logic [7:0]  alpha;
		logic [23:0] held_pix[3];
		logic [2:0]  held_user;
		int unsigned held_cnt;
		word_t       owed_words[$];
		int          mismatches;
		int          words_checked;
		int          pixels_noted;

		function new();
			mode          = MODE_ALPHA;
			alpha         = 8'h00;
			mismatches    = 0;
			words_checked = 0;
			pixels_noted  = 0;
			clear_group();
		endfunction

		function void clear_group();
			foreach (held_pix[i])
				held_pix[i] = '0;
			held_user = '0;
			held_cnt  = 0;
		endfunction

		function void owe_word(logic [31:0] d, logic u, logic l);
			word_t w;
			w.data = d;
			w.user = u;
			w.last = l;
			owed_words.push_back(w);
		endfunction

		// a mode write drops whatever group was being gathered
		function void write_reg(logic idx, logic [7:0] val);
			if (idx == CFG_PACK_MODE) begin
				mode = val[2:0];
				clear_group();
			end else begin
				alpha = val;
			end
		endfunction

		// one accepted pixel beat, queue the words it completes
		function void note_pixel(logic [23:0] pix, logic usr, logic lst);
			int unsigned group_len;
			int unsigned n;
			int unsigned n_words;
			logic [23:0] p[4];
			logic [3:0]  u;
			logic [8:0]  cb_sum;
			logic [8:0]  cr_sum;
			logic [31:0] w[3];
			pixels_noted++;
			if (mode > MODE_CHROMA)
				return;
			if (mode == MODE_ALPHA) begin
				owe_word({alpha, pix}, usr, lst);
				return;
			end
			group_len = (mode == MODE_DENSE || mode == MODE_BYTE) ? 4 : 2;
			n = held_cnt;
			if (n >= group_len)
				n = group_len - 1;
			// still gathering
			if (n + 1 < group_len && !lst) begin
				held_pix[n]  = pix;
				held_user[n] = usr;
				held_cnt     = n + 1;
				return;
			end
			// missing pixels of a short group read as zero
			u = '0;
			for (int i = 0; i < 4; i++) begin
				p[i] = '0;
				if (i < n) begin
					p[i] = held_pix[i];
					u[i] = held_user[i];
				end
			end
			p[n] = pix;
			u[n] = usr;
			n    = n + 1;
			case (mode)
				MODE_DENSE: begin
					n_words = (n * 24 + 31) / 32;
					w[0] = {p[1][7:0], p[0]};
					w[1] = {p[2][15:0], p[1][23:8]};
					w[2] = {p[3], p[2][23:16]};
					for (int i = 0; i < n_words; i++)
						owe_word(w[i], u[i], (i + 1 == n_words) ? lst : 1'b0);
				end
				MODE_BYTE: begin
					owe_word({p[3][7:0], p[2][7:0], p[1][7:0], p[0][7:0]}, |u, lst);
				end
				MODE_HALF: begin
					owe_word({p[1][15:0], p[0][15:0]}, |u, lst);
				end
				default: begin
					cb_sum = {1'b0, p[0][15:8]} + {1'b0, p[1][15:8]};
					cr_sum = {1'b0, p[0][23:16]} + {1'b0, p[1][23:16]};
					owe_word({cr_sum[8:1], p[1][7:0], cb_sum[8:1], p[0][7:0]}, |u, lst);
				end
			endcase
			clear_group();
		endfunction

		// one accepted output beat against the oldest owed word
		function void check_word(logic [31:0] d, logic u, logic l);
			word_t want;
			words_checked++;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("tb: word %0d not expected: data=%h user=%b last=%b",
						words_checked, d, u, l);
				return;
			end
			want = owed_words.pop_front();
			if (d !== want.data || u !== want.user || l !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("tb: word %0d expected data=%h user=%b last=%b, %s",
						words_checked, want.data, want.user, want.last,
						$sformatf("got data=%h user=%b last=%b", d, u, l));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_wr        = 1'b0;
	logic        cfg_index     = CFG_PACK_MODE;
	logic [7:0]  cfg_data      = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // pixel_data[23:0]
	logic        s_axis_tuser  = 1'b0; // pixel_user
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // word_data[31:0]
	logic        m_axis_tuser;         // word_user
	logic        m_axis_tlast;

	pack_scoreboard sb = new();
	bit gaps_on      = 1'b1;
	int sink_hold    = 0;
	int cycles       = 0;
	int random_sent  = 0;
	int phases       = 0;

	pixel_stream_packer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// sink side ready with random stall bursts
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold     <= sink_hold - 1;
			m_axis_tready <= (sink_hold == 1);
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			sink_hold     <= $urandom_range(1, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// register writes, accepted pixels and accepted words, in that order per edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr)
				sb.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_pixel(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// one pixel beat, with an occasional source gap first
	task send_pixel(input logic [23:0] pix, input logic usr, input logic lst);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= usr;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// stop sending and let every owed word come out
	task wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write mode then alpha on back-to-back edges
	task set_config(input logic [2:0] mode_code, input logic [7:0] alpha_byte);
		cfg_wr    <= 1'b1;
		cfg_index <= CFG_PACK_MODE;
		cfg_data  <= {5'b0, mode_code};
		@(posedge clk);
		cfg_index <= CFG_ALPHA_VALUE;
		cfg_data  <= alpha_byte;
		@(posedge clk);
		cfg_wr <= 1'b0;
	endtask

	// random frames of 1 to 9 pixels, mostly marked with user on the first beat
	task send_frames(input int n_pix);
		int frame_len;
		int sent;
		logic [23:0] pix;
		logic usr;
		sent = 0;
		while (sent < n_pix) begin
			frame_len = $urandom_range(1, 9);
			for (int i = 0; i < frame_len && sent < n_pix; i++) begin
				case ($urandom_range(0, 7))
					0:       pix = 24'hFFFFFF;
					1:       pix = 24'h000000;
					default: pix = 24'($urandom_range(0, 24'hFFFFFF));
				endcase
				if (i == 0)
					usr = ($urandom_range(0, 3) != 0);
				else
					usr = ($urandom_range(0, 7) == 0);
				send_pixel(pix, usr, i == frame_len - 1);
				sent++;
			end
		end
		random_sent += sent;
	endtask

	initial begin
		logic [2:0] mode_pick;
		logic [7:0] alpha_pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// alpha mode straight out of reset
		send_pixel(24'hFFFFFF, 1'b1, 1'b0);
		send_pixel(24'h000000, 1'b0, 1'b1);
		wait_idle();

		// dense: full group with last, then short groups of three, two and one
		set_config(MODE_DENSE, 8'hFF);
		send_pixel(24'hFFFFFF, 1'b1, 1'b0);
		send_pixel(24'h000000, 1'b0, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1, 1'b0);
		send_pixel(24'h000000, 1'b0, 1'b1);
		send_pixel(24'h123456, 1'b0, 1'b0);
		send_pixel(24'h789ABC, 1'b1, 1'b0);
		send_pixel(24'hDEF012, 1'b0, 1'b1);
		send_pixel(24'hA5A5A5, 1'b0, 1'b0);
		send_pixel(24'h5A5A5A, 1'b0, 1'b1);
		send_pixel(24'hC0FFEE, 1'b1, 1'b1);
		wait_idle();

		// sixteen-bit: user on the second pixel, then a stray pixel the mode write drops
		set_config(MODE_HALF, 8'h00);
		send_pixel(24'h00FFFF, 1'b0, 1'b0);
		send_pixel(24'hFF0001, 1'b1, 1'b0);
		send_pixel(24'h777777, 1'b1, 1'b0);
		wait_idle();

		// alpha byte at its top value
		set_config(MODE_ALPHA, 8'hFF);
		send_pixel(24'h000000, 1'b0, 1'b0);
		wait_idle();

		// eight-bit: short group with zero fill
		set_config(MODE_BYTE, 8'h80);
		send_pixel(24'hFFFF11, 1'b0, 1'b0);
		send_pixel(24'h000022, 1'b1, 1'b1);
		wait_idle();

		// 4:2:2: truncating chroma mean, then a lone pixel ending the frame
		set_config(MODE_CHROMA, 8'h01);
		send_pixel(24'hFF80FF, 1'b1, 1'b0);
		send_pixel(24'h008100, 1'b0, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0, 1'b1);
		wait_idle();

		// undefined mode swallows everything
		set_config(MODE_UNUSED, 8'h00);
		send_pixel(24'h345678, 1'b1, 1'b0);
		send_pixel(24'h876543, 1'b0, 1'b1);
		wait_idle();

		// random phases, the final ones without source gaps or sink stalls
		while (random_sent < RANDOM_PIXELS) begin
			phases++;
			if (RANDOM_PIXELS - random_sent <= 25)
				gaps_on = 1'b0;
			mode_pick = 3'($urandom_range(MODE_DENSE, MODE_CHROMA));
			case ($urandom_range(0, 3))
				0:       alpha_pick = 8'h00;
				1:       alpha_pick = 8'hFF;
				default: alpha_pick = 8'($urandom_range(0, 255));
			endcase
			set_config(mode_pick, alpha_pick);
			send_frames($urandom_range(12, 24));
			wait_idle();
		end

		if (sb.owed_words.size() != 0) begin
			sb.mismatches += sb.owed_words.size();
			$display("tb: %0d words never arrived", sb.owed_words.size());
		end
		$display("tb: %0d pixels driven, %0d words checked, %0d random mode phases",
			sb.pixels_noted, sb.words_checked, phases);
		$display("tb: covered all packing modes, the undefined mode, short frames and stalls");
		if (sb.mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/psp_pkg.sv
hdl/psp_pack.sv
hdl/psp_word_queue.sv
hdl/pixel_stream_packer.sv
sim/tb.sv
